[rtl/core/ilf_pkg.sv]
// Shared constants, codes and control types of the interval list intersection filter.
`default_nettype none
package ilf_pkg;

	localparam int MAX_INTERVALS = 1024;
	localparam int NUM_LISTS     = 4;
	localparam int LIST_W        = 2;
	localparam int CELL_W        = 32;
	localparam int ENTRY_W       = 2 * CELL_W;
	localparam int PRED_W        = 2;
	localparam int IDX_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
	localparam int BANK_DEPTH    = 2 * (1 << IDX_W);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	localparam logic [PRED_W-1:0] PRED_INTERSECTS = 2'd0;
	localparam logic [PRED_W-1:0] PRED_DISJOINT   = 2'd1;
	localparam logic [PRED_W-1:0] PRED_MEET       = 2'd2;

	typedef enum logic [1:0] {
		VERD_NEG   = 2'd0,
		VERD_HIT   = 2'd1,
		VERD_INCON = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		WALK_AA = 2'd0,
		WALK_AF = 2'd1,
		WALK_FA = 2'd2
	} walk_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic     load;
		logic     ptr_clr;
		logic     adv;
		logic     push;
		walk_t    walk;
		verdict_t verdict;
	} cmd_t;

	typedef struct packed {
		logic              empty;
		logic              overlap;
		logic              last;
		logic              out_free;
		logic [PRED_W-1:0] predicate;
	} sts_t;

endpackage
`default_nettype wire

[rtl/core/ilf_req_if.sv]
// Input channel carrying load and evaluate beats.
`default_nettype none
interface ilf_req_if;
	import ilf_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [LIST_W-1:0]         list_select;
	logic [CELL_W-1:0]         interval_start;
	logic [CELL_W-1:0]         interval_end;

	modport source (output valid, kind, list_select, interval_start, interval_end,
		input ready);
	modport sink (input valid, kind, list_select, interval_start, interval_end,
		output ready);
endinterface
`default_nettype wire

[rtl/core/ilf_rsp_if.sv]
// Result channel carrying verdict beats.
`default_nettype none
interface ilf_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic       overflow;

	modport source (output valid, verdict, overflow, input ready);
	modport sink (input valid, verdict, overflow, output ready);
endinterface
`default_nettype wire

[rtl/core/ilf_cfg_if.sv]
// Configuration write channel for the predicate register.
`default_nettype none
interface ilf_cfg_if;
	import ilf_pkg::*;

	logic              valid;
	logic              ready;
	logic [PRED_W-1:0] predicate;

	modport source (output valid, predicate, input ready);
	modport sink (input valid, predicate, output ready);
endinterface
`default_nettype wire

[rtl/core/interval_list_intersection_filter.sv]
// Top level of the interval list intersection filter.
// Usage:
//   req  : load beats (kind 0) append [interval_start, interval_end) to the list picked
//          by list_select (R all, R full, S all, S full); an evaluate beat (kind 1) runs
//          the merge walks, returns one verdict beat on rsp and clears all lists.
//   rsp  : one beat per evaluate with verdict and the overflow flag of dropped loads.
//   cfg  : writes the predicate register; always ready, write only while idle.
// Sequencing:
//   Loads are accepted back to back while idle, even while a verdict beat still
//   waits on rsp.
//   An evaluate runs up to three walks (AA, then AF, then FA). A walk over lists of
//   n1 and n2 entries has a setup step, then a registered bank read and a compare
//   for each compared head pair, at most n1 + n2 - 1 pairs; an empty list ends it
//   in the setup step. A handoff state follows the walks, req ready stays low
//   throughout, and the verdict beat appears on rsp the cycle after the handoff
//   pushes it.
// Reset: clears list counts, overflow flag, predicate (intersects) and rsp valid.
//   Bank contents are not cleared; only entries below a list's count are read.
// Stall: the verdict is held on rsp until taken; a finished evaluate waits for a
//   free result slot before it clears the lists and takes new beats.
`default_nettype none
module interval_list_intersection_filter (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ilf_req_if.sink     req,
	ilf_rsp_if.source   rsp,
	ilf_cfg_if.sink     cfg
);
	import ilf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	ilf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_kind  (req.kind),
		.in_ready (req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ilf_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.list_select    (req.list_select),
		.interval_start (req.interval_start),
		.interval_end   (req.interval_end),
		.cfg_valid      (cfg.valid),
		.cfg_predicate  (cfg.predicate),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.out_verdict    (rsp.verdict),
		.out_overflow   (rsp.overflow)
	);
endmodule
`default_nettype wire

[rtl/core/ilf_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ilf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

[rtl/core/ilf_ctrl.sv]
// Controller sequencing the AA, AF and FA merge walks and the result handoff.
`default_nettype none
module ilf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_kind,
	output logic               in_ready,
	output ilf_pkg::cmd_t      cmd,
	input  wire ilf_pkg::sts_t sts
);
	import ilf_pkg::*;

	state_t   state_q, state_d;
	walk_t    walk_q, walk_d;
	verdict_t verdict_q, verdict_d;
	logic     resolve;
	logic     found;
	verdict_t hit_map;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			walk_q    <= WALK_AA;
			verdict_q <= VERD_NEG;
		end else begin
			state_q   <= state_d;
			walk_q    <= walk_d;
			verdict_q <= verdict_d;
		end
	end

	assign hit_map = (sts.predicate == PRED_DISJOINT || sts.predicate == PRED_MEET)
		? VERD_NEG : VERD_HIT;

	always_comb begin
		state_d   = state_q;
		walk_d    = walk_q;
		verdict_d = verdict_q;
		resolve   = 1'b0;
		found     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_kind == KIND_EVAL) begin
					state_d = ST_START;
					walk_d  = WALK_AA;
				end
			end
			ST_START: begin
				if (sts.empty) begin
					resolve = 1'b1;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (sts.overlap) begin
					resolve = 1'b1;
					found   = 1'b1;
				end else if (sts.last) begin
					resolve = 1'b1;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (resolve) begin
			case (walk_q)
				WALK_AA: begin
					if (!found) begin
						verdict_d = (sts.predicate == PRED_DISJOINT) ? VERD_HIT : VERD_NEG;
						state_d   = ST_DONE;
					end else begin
						walk_d  = WALK_AF;
						state_d = ST_START;
					end
				end
				WALK_AF: begin
					if (found) begin
						verdict_d = hit_map;
						state_d   = ST_DONE;
					end else begin
						walk_d  = WALK_FA;
						state_d = ST_START;
					end
				end
				WALK_FA: begin
					verdict_d = found ? hit_map : VERD_INCON;
					state_d   = ST_DONE;
				end
				default: begin
					verdict_d = VERD_INCON;
					state_d   = ST_DONE;
				end
			endcase
		end
	end

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cmd.load    = (state_q == ST_IDLE) && in_valid && (in_kind == KIND_LOAD);
		cmd.ptr_clr = (state_q == ST_START);
		cmd.adv     = (state_q == ST_CMP) && !sts.overlap;
		cmd.push    = (state_q == ST_DONE) && sts.out_free;
		cmd.walk    = walk_q;
		cmd.verdict = verdict_q;
	end
endmodule
`default_nettype wire

[rtl/core/ilf_datapath.sv]
// Datapath: interval banks, list counts, walk pointers, head compare and result register.
`default_nettype none
module ilf_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [ilf_pkg::LIST_W-1:0]   list_select,
	input  wire logic [ilf_pkg::CELL_W-1:0]   interval_start,
	input  wire logic [ilf_pkg::CELL_W-1:0]   interval_end,
	input  wire logic                         cfg_valid,
	input  wire logic [ilf_pkg::PRED_W-1:0]   cfg_predicate,
	input  wire ilf_pkg::cmd_t                cmd,
	output ilf_pkg::sts_t                     sts,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        out_verdict,
	output logic                              out_overflow
);
	import ilf_pkg::*;

	localparam int ADDR_W = IDX_W + 1;

	logic [CNT_W-1:0]   cnt_q [NUM_LISTS];
	logic [CNT_W-1:0]   ptr_a_q, ptr_b_q;
	logic               overflow_q;
	logic [PRED_W-1:0]  predicate_q;
	logic               out_valid_q;
	logic [1:0]         verdict_q;
	logic               out_ovf_q;

	logic               load_ok;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               we_a, we_b;
	logic               a_list, b_list;
	logic [CNT_W-1:0]   cnt_a, cnt_b;
	logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;
	logic [ENTRY_W-1:0] rd_a, rd_b;
	logic [CELL_W-1:0]  sa, ea, sb, eb;
	logic               a_first;
	logic               out_free;

	assign load_ok = cnt_q[list_select] < CNT_W'(MAX_INTERVALS);
	assign wr_addr = {list_select[0], cnt_q[list_select][IDX_W-1:0]};
	assign wr_data = {interval_end, interval_start};
	assign we_a    = cmd.load && load_ok && !list_select[1];
	assign we_b    = cmd.load && load_ok && list_select[1];

	assign a_list    = (cmd.walk == WALK_FA);
	assign b_list    = (cmd.walk == WALK_AF);
	assign cnt_a     = cnt_q[{1'b0, a_list}];
	assign cnt_b     = cnt_q[{1'b1, b_list}];
	assign rd_addr_a = {a_list, ptr_a_q[IDX_W-1:0]};
	assign rd_addr_b = {b_list, ptr_b_q[IDX_W-1:0]};

	ilf_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_bank_r (
		.clk     (clk),
		.we      (we_a),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr_a),
		.rd_data (rd_a)
	);

	ilf_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_bank_s (
		.clk     (clk),
		.we      (we_b),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr_b),
		.rd_data (rd_b)
	);

	assign sa      = rd_a[CELL_W-1:0];
	assign ea      = rd_a[ENTRY_W-1:CELL_W];
	assign sb      = rd_b[CELL_W-1:0];
	assign eb      = rd_b[ENTRY_W-1:CELL_W];
	assign a_first = (sa <= sb);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		sts.empty     = (cnt_a == '0) || (cnt_b == '0);
		sts.overlap   = a_first ? (ea > sb) : (eb > sa);
		sts.last      = a_first ? ((ptr_a_q + CNT_W'(1)) == cnt_a)
		                        : ((ptr_b_q + CNT_W'(1)) == cnt_b);
		sts.out_free  = out_free;
		sts.predicate = predicate_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				cnt_q[i] <= '0;
			end
			overflow_q  <= 1'b0;
			predicate_q <= PRED_INTERSECTS;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				predicate_q <= cfg_predicate;
			end
			if (cmd.push) begin
				for (int i = 0; i < NUM_LISTS; i++) begin
					cnt_q[i] <= '0;
				end
				overflow_q <= 1'b0;
			end else if (cmd.load) begin
				if (load_ok) begin
					cnt_q[list_select] <= cnt_q[list_select] + CNT_W'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ptr_clr) begin
			ptr_a_q <= '0;
			ptr_b_q <= '0;
		end else if (cmd.adv) begin
			if (a_first) begin
				ptr_a_q <= ptr_a_q + CNT_W'(1);
			end else begin
				ptr_b_q <= ptr_b_q + CNT_W'(1);
			end
		end
		if (cmd.push) begin
			verdict_q <= cmd.verdict;
			out_ovf_q <= overflow_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_verdict  = verdict_q;
	assign out_overflow = out_ovf_q;
endmodule
`default_nettype wire
